>>> src/kcm_pkg.sv
// ----------------------------------------------------------------------------
// kcm_pkg
// Shared types and constants for the keyed count merge table.
// ----------------------------------------------------------------------------
`default_nettype none

package kcm_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int NAME_BYTES  = 32;
  localparam int CHUNK_W     = 64;
  localparam int CHUNKS      = (NAME_BYTES + 7) / 8;
  localparam int KEY_W       = CHUNKS * CHUNK_W;
  localparam int CHUNK_IDX_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int POS_W       = $clog2(CHUNKS + 1);
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int USED_W      = $clog2(TABLE_DEPTH + 1);
  localparam int COUNT_W     = 32;

  // Field widths fixed by the interface
  localparam int OP_W     = 2;
  localparam int STATUS_W = 3;
  localparam int RIDX_W   = 10;
  localparam int RCHUNK_W = 2;
  localparam int OIDX_W   = 10;
  localparam int OUSED_W  = 11;

  // Stream data widths (whole bytes)
  localparam int S_DATA_BITS = CHUNK_W + COUNT_W + RIDX_W + RCHUNK_W;
  localparam int S_DATA_W    = ((S_DATA_BITS + 7) / 8) * 8;
  localparam int M_DATA_BITS = OIDX_W + COUNT_W + CHUNK_W + OUSED_W;
  localparam int M_DATA_W    = ((M_DATA_BITS + 7) / 8) * 8;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Input op codes
  localparam logic [OP_W-1:0] OP_CHUNK = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_TAKEN    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ADDED    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_READ_OK  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_READ_BAD = 3'd5;

  typedef logic [CHUNKS-1:0][CHUNK_W-1:0] key_t;

  typedef enum logic [1:0] {
    CMD_TAKEN,
    CMD_MERGE,
    CMD_READ,
    CMD_CLEAR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t             kind;
    key_t                  key;
    logic [COUNT_W-1:0]    add_count;
    logic [RIDX_W-1:0]     read_index;
    logic [RCHUNK_W-1:0]   read_chunk;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SEARCH,
    BK_ADD,
    BK_READ,
    BK_EMIT
  } back_state_t;

endpackage

`default_nettype wire

>>> src/kcm_front.sv
// ----------------------------------------------------------------------------
// kcm_front
// Accepts input transactions, assembles the key chunks of a name, normalises
// the key on the last chunk and turns each transaction into a command.
// ----------------------------------------------------------------------------
`default_nettype none

module kcm_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [kcm_pkg::S_DATA_W-1:0]  s_tdata,
  input  wire logic [kcm_pkg::OP_W-1:0]      s_tuser,
  input  wire logic                          s_tlast,
  output logic                               q_push,
  input  wire logic                          q_full,
  output kcm_pkg::cmd_t                      q_wdata
);

  kcm_pkg::key_t                   asm_key;
  logic [kcm_pkg::POS_W-1:0]       pos;
  kcm_pkg::key_t                   full_key;
  logic [kcm_pkg::CHUNK_W-1:0]     in_chunk;
  logic                            accept;

  // Clear bytes from the first zero byte on, and from the terminator slot on
  function automatic kcm_pkg::key_t normalise(input kcm_pkg::key_t k);
    logic                     keep;
    logic [kcm_pkg::KEY_W-1:0] flat;
    keep = 1'b1;
    flat = k;
    for (int b = 0; b < kcm_pkg::CHUNKS * 8; b++) begin
      keep = keep && (flat[b*8 +: 8] != 8'd0) && (b < kcm_pkg::NAME_BYTES - 1);
      if (!keep) begin
        flat[b*8 +: 8] = 8'd0;
      end
    end
    return kcm_pkg::key_t'(flat);
  endfunction

  assign in_chunk = s_tdata[kcm_pkg::CHUNK_W-1:0];
  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign q_push   = accept;

  // Key as it stands with this chunk written into its slot
  always_comb begin
    full_key = asm_key;
    if (pos < kcm_pkg::POS_W'(kcm_pkg::CHUNKS)) begin
      full_key[pos[kcm_pkg::CHUNK_IDX_W-1:0]] = in_chunk;
    end
  end

  // Command classification
  always_comb begin
    q_wdata.kind       = kcm_pkg::CMD_TAKEN;
    q_wdata.key        = normalise(full_key);
    q_wdata.add_count  = s_tdata[kcm_pkg::CHUNK_W +: kcm_pkg::COUNT_W];
    q_wdata.read_index = s_tdata[kcm_pkg::CHUNK_W + kcm_pkg::COUNT_W +: kcm_pkg::RIDX_W];
    q_wdata.read_chunk = s_tdata[kcm_pkg::CHUNK_W + kcm_pkg::COUNT_W + kcm_pkg::RIDX_W
                                 +: kcm_pkg::RCHUNK_W];
    case (s_tuser)
      kcm_pkg::OP_CHUNK: q_wdata.kind = s_tlast ? kcm_pkg::CMD_MERGE : kcm_pkg::CMD_TAKEN;
      kcm_pkg::OP_READ:  q_wdata.kind = kcm_pkg::CMD_READ;
      kcm_pkg::OP_CLEAR: q_wdata.kind = kcm_pkg::CMD_CLEAR;
      default:           q_wdata.kind = kcm_pkg::CMD_TAKEN;
    endcase
  end

  // Name assembly; a merge or a clear starts a fresh name
  always_ff @(posedge clk) begin
    if (rst) begin
      asm_key <= '0;
      pos     <= '0;
    end else if (accept) begin
      if (s_tuser == kcm_pkg::OP_CLEAR ||
          (s_tuser == kcm_pkg::OP_CHUNK && s_tlast)) begin
        asm_key <= '0;
        pos     <= '0;
      end else if (s_tuser == kcm_pkg::OP_CHUNK &&
                   pos < kcm_pkg::POS_W'(kcm_pkg::CHUNKS)) begin
        asm_key <= full_key;
        pos     <= pos + kcm_pkg::POS_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> src/kcm_queue.sv
// ----------------------------------------------------------------------------
// kcm_queue
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module kcm_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire kcm_pkg::cmd_t wdata,
  output logic               full,
  input  wire logic          pop,
  output logic               valid,
  output kcm_pkg::cmd_t      rdata
);

  kcm_pkg::cmd_t               store [kcm_pkg::QUEUE_DEPTH];
  logic [kcm_pkg::QPTR_W-1:0]  wptr;
  logic [kcm_pkg::QPTR_W-1:0]  rptr;
  logic [kcm_pkg::QCNT_W-1:0]  fill;
  logic                        do_push;
  logic                        do_pop;

  assign full    = (fill == kcm_pkg::QCNT_W'(kcm_pkg::QUEUE_DEPTH));
  assign valid   = (fill != '0);
  assign rdata   = store[rptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wptr] <= wdata;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + kcm_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rptr <= rptr + kcm_pkg::QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + kcm_pkg::QCNT_W'(1);
        2'b01:   fill <= fill - kcm_pkg::QCNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/kcm_back.sv
// ----------------------------------------------------------------------------
// kcm_back
// Carries out commands against the key and count memories: linear search
// one entry per cycle, merge or append, entry reads, clear; holds the result
// register towards the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module kcm_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          q_valid,
  input  wire kcm_pkg::cmd_t                 q_data,
  output logic                               q_pop,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [kcm_pkg::M_DATA_W-1:0]       m_tdata,
  output logic [kcm_pkg::STATUS_W-1:0]       m_tuser
);

  // Memories: one row of key chunks per entry, one count per entry
  logic [kcm_pkg::KEY_W-1:0]     key_mem [kcm_pkg::TABLE_DEPTH];
  logic [kcm_pkg::COUNT_W-1:0]   cnt_mem [kcm_pkg::TABLE_DEPTH];
  kcm_pkg::key_t                 key_rd;
  logic [kcm_pkg::COUNT_W-1:0]   cnt_rd;

  kcm_pkg::back_state_t          state, state_next;
  kcm_pkg::cmd_t                 cmd, cmd_next;
  logic [kcm_pkg::USED_W-1:0]    entry_total, entry_total_next;
  logic [kcm_pkg::USED_W-1:0]    scan_idx, scan_idx_next;
  logic                          cmp_vld, cmp_vld_next;
  logic [kcm_pkg::IDX_W-1:0]     cmp_idx, cmp_idx_next;

  logic [kcm_pkg::STATUS_W-1:0]  res_status, res_status_next;
  logic [kcm_pkg::IDX_W-1:0]     res_idx, res_idx_next;
  logic [kcm_pkg::COUNT_W-1:0]   res_total, res_total_next;
  logic [kcm_pkg::CHUNK_W-1:0]   res_kout, res_kout_next;

  logic [kcm_pkg::IDX_W-1:0]     key_raddr, cnt_raddr, cnt_waddr;
  logic                          key_we, cnt_we, out_load;
  logic [kcm_pkg::COUNT_W-1:0]   cnt_wdata;
  logic [kcm_pkg::COUNT_W:0]     sum;
  logic                          hit;

  assign hit = cmp_vld && (key_rd == cmd.key);
  assign sum = {1'b0, cnt_rd} + {1'b0, cmd.add_count};

  // Sequencer: next state and datapath control
  always_comb begin
    state_next       = state;
    cmd_next         = cmd;
    entry_total_next = entry_total;
    scan_idx_next    = scan_idx;
    cmp_vld_next     = 1'b0;
    cmp_idx_next     = cmp_idx;
    res_status_next  = res_status;
    res_idx_next     = res_idx;
    res_total_next   = res_total;
    res_kout_next    = res_kout;
    q_pop            = 1'b0;
    key_raddr        = scan_idx[kcm_pkg::IDX_W-1:0];
    cnt_raddr        = cmp_idx;
    key_we           = 1'b0;
    cnt_we           = 1'b0;
    cnt_waddr        = entry_total[kcm_pkg::IDX_W-1:0];
    cnt_wdata        = cmd.add_count;
    out_load         = 1'b0;
    case (state)
      kcm_pkg::BK_IDLE: begin
        key_raddr = kcm_pkg::IDX_W'(q_data.read_index);
        cnt_raddr = kcm_pkg::IDX_W'(q_data.read_index);
        if (q_valid) begin
          q_pop           = 1'b1;
          cmd_next        = q_data;
          res_status_next = kcm_pkg::ST_TAKEN;
          res_idx_next    = '0;
          res_total_next  = '0;
          res_kout_next   = '0;
          case (q_data.kind)
            kcm_pkg::CMD_MERGE: begin
              scan_idx_next = '0;
              state_next    = kcm_pkg::BK_SEARCH;
            end
            kcm_pkg::CMD_READ: begin
              if (kcm_pkg::USED_W'(q_data.read_index) < entry_total) begin
                state_next = kcm_pkg::BK_READ;
              end else begin
                res_status_next = kcm_pkg::ST_READ_BAD;
                state_next      = kcm_pkg::BK_EMIT;
              end
            end
            kcm_pkg::CMD_CLEAR: begin
              entry_total_next = '0;
              state_next       = kcm_pkg::BK_EMIT;
            end
            default: begin
              state_next = kcm_pkg::BK_EMIT;
            end
          endcase
        end
      end
      kcm_pkg::BK_SEARCH: begin
        if (hit) begin
          // fetch the count of the matching entry
          cnt_raddr    = cmp_idx;
          res_idx_next = cmp_idx;
          state_next   = kcm_pkg::BK_ADD;
        end else if (scan_idx < entry_total) begin
          key_raddr     = scan_idx[kcm_pkg::IDX_W-1:0];
          cmp_vld_next  = 1'b1;
          cmp_idx_next  = scan_idx[kcm_pkg::IDX_W-1:0];
          scan_idx_next = scan_idx + kcm_pkg::USED_W'(1);
        end else if (entry_total == kcm_pkg::USED_W'(kcm_pkg::TABLE_DEPTH)) begin
          res_status_next = kcm_pkg::ST_DROPPED;
          state_next      = kcm_pkg::BK_EMIT;
        end else begin
          // miss: append a new entry
          key_we           = 1'b1;
          cnt_we           = 1'b1;
          cnt_waddr        = entry_total[kcm_pkg::IDX_W-1:0];
          cnt_wdata        = cmd.add_count;
          res_status_next  = kcm_pkg::ST_INSERTED;
          res_idx_next     = entry_total[kcm_pkg::IDX_W-1:0];
          res_total_next   = cmd.add_count;
          entry_total_next = entry_total + kcm_pkg::USED_W'(1);
          state_next       = kcm_pkg::BK_EMIT;
        end
      end
      kcm_pkg::BK_ADD: begin
        // saturating add at the count maximum
        cnt_we          = 1'b1;
        cnt_waddr       = res_idx;
        cnt_wdata       = sum[kcm_pkg::COUNT_W] ? '1 : sum[kcm_pkg::COUNT_W-1:0];
        res_status_next = kcm_pkg::ST_ADDED;
        res_total_next  = cnt_wdata;
        state_next      = kcm_pkg::BK_EMIT;
      end
      kcm_pkg::BK_READ: begin
        res_status_next = kcm_pkg::ST_READ_OK;
        res_idx_next    = kcm_pkg::IDX_W'(cmd.read_index);
        res_total_next  = cnt_rd;
        res_kout_next   = key_rd[kcm_pkg::CHUNK_IDX_W'(cmd.read_chunk)];
        state_next      = kcm_pkg::BK_EMIT;
      end
      kcm_pkg::BK_EMIT: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = kcm_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = kcm_pkg::BK_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= kcm_pkg::BK_IDLE;
      entry_total <= '0;
      cmp_vld     <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      state       <= state_next;
      entry_total <= entry_total_next;
      cmp_vld     <= cmp_vld_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd        <= cmd_next;
    scan_idx   <= scan_idx_next;
    cmp_idx    <= cmp_idx_next;
    res_status <= res_status_next;
    res_idx    <= res_idx_next;
    res_total  <= res_total_next;
    res_kout   <= res_kout_next;
    if (out_load) begin
      m_tuser <= res_status;
      m_tdata <= {(kcm_pkg::M_DATA_W - kcm_pkg::M_DATA_BITS)'(0),
                  kcm_pkg::OUSED_W'(entry_total),
                  res_kout,
                  res_total,
                  kcm_pkg::OIDX_W'(res_idx)};
    end
  end

  // Key memory
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[entry_total[kcm_pkg::IDX_W-1:0]] <= cmd.key;
    end
    key_rd <= key_mem[key_raddr];
  end

  // Count memory
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rd <= cnt_mem[cnt_raddr];
  end

endmodule

`default_nettype wire

>>> src/keyed_count_merge_table_core.sv
// Throughput: one transaction at a time in the back; the search compares one
//   stored key per cycle on the key memory read port, up to 1024 entries.
// Reset: synchronous; empties the table and the name assembly at once; the
//   memories are not cleared, as only entries below the fill count are read.
// ----------------------------------------------------------------------------
// keyed_count_merge_table_core
// Keyed count table: front assembles names, queue decouples, back merges.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_count_merge_table_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // key_chunk[63:0], add_count[95:64], read_index[105:96], read_chunk[107:106]
  input  wire logic [kcm_pkg::S_DATA_W-1:0]  s_tdata,
  // op[1:0]
  input  wire logic [kcm_pkg::OP_W-1:0]      s_tuser,
  input  wire logic                          s_tlast,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // entry_index[9:0], total_count[41:10], key_chunk_out[105:42], used_entries[116:106]
  output logic [kcm_pkg::M_DATA_W-1:0]       m_tdata,
  // status[2:0]
  output logic [kcm_pkg::STATUS_W-1:0]       m_tuser
);

  logic          q_push, q_full, q_pop, q_valid;
  kcm_pkg::cmd_t q_wdata, q_rdata;

  // Front: accept and classify
  kcm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .q_push   (q_push),
    .q_full   (q_full),
    .q_wdata  (q_wdata)
  );

  // Command queue
  kcm_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  // Back: search, merge, read
  kcm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_rdata),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire
